// ----- src/sensor_log_statistics_assert.svh -----
// Assertion macros shared by the sensor log statistics RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef SENSOR_LOG_STATISTICS_ASSERT_SVH
`define SENSOR_LOG_STATISTICS_ASSERT_SVH

// Condition and consequence checked in the same cycle.
`define SLS_ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("sensor log statistics: same-cycle check failed");

// Consequence checked in the cycle after the condition.
`define SLS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("sensor log statistics: next-cycle check failed");

`endif

// ----- src/slstat_pkg.sv -----
// Shared types and constants of the sensor log statistics block.
// Depends on nothing; used by every module of the block.
`default_nettype none

package slstat_pkg;

	localparam int VAL_W      = 13;
	localparam int ENTRY_W    = 2 * VAL_W;
	localparam int FRAC_W     = 8;
	localparam int RES_W      = VAL_W + FRAC_W;
	localparam int SUM_W      = 19;
	localparam int DIVIDEND_W = SUM_W + FRAC_W;
	localparam int STEP_W     = $clog2(DIVIDEND_W + 1);
	localparam int COUNT_W    = 7;
	localparam int REQ_W      = 3;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOINIT = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Code seven carries no request and is dropped without a reply.
	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 3'd0,
		REQ_AVG    = 3'd1,
		REQ_MIN    = 3'd2,
		REQ_MAX    = 3'd3,
		REQ_DUMP   = 3'd4,
		REQ_CLEAR  = 3'd5,
		REQ_INIT   = 3'd6,
		REQ_UNUSED = 3'd7
	} req_t;

endpackage

`default_nettype wire

// ----- src/sensor_log_statistics.sv -----
// Sensor log statistics, top level. Add, minimum, maximum, clear, init and the
// error replies answer in the cycle after acceptance, one word per cycle. Average
// answers once both dividers have run their 27 steps, and the block is ready again
// as the answer appears; dump alternates a read of the log memory, whose read data
// is registered, with sending that entry. Results cannot be stalled. Reset clears
// the fill count, sums, extremes and enable; the log memory is left as it is.
`default_nettype none
`include "sensor_log_statistics_assert.svh"

module sensor_log_statistics #(
	parameter int LOG_DEPTH = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  [slstat_pkg::REQ_W-1:0]     req_type,
	input  wire  [slstat_pkg::VAL_W-1:0]     temperature,
	input  wire  [slstat_pkg::VAL_W-1:0]     humidity,
	input  wire  [25:0]                      init_size,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [slstat_pkg::RES_W-1:0]     temp_value,
	output logic [slstat_pkg::RES_W-1:0]     hum_value,
	output logic [slstat_pkg::COUNT_W-1:0]   entry_count,
	output logic                             last
);
	import slstat_pkg::*;

	// The fill count must hold the depth itself; the address only the entries.
	localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
	localparam int ADDR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_DUMP_RD,
		S_DUMP_OUT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    fill_q;
	logic                enabled_q;
	logic [SUM_W-1:0]    tsum_q;
	logic [SUM_W-1:0]    hsum_q;
	logic [VAL_W-1:0]    tmin_q;
	logic [VAL_W-1:0]    tmax_q;
	logic [VAL_W-1:0]    hmin_q;
	logic [VAL_W-1:0]    hmax_q;
	logic [CNT_W-1:0]    idx_q;

	logic                done_q;
	status_t             status_q;
	logic [RES_W-1:0]    temp_q;
	logic [RES_W-1:0]    hum_q;
	logic [COUNT_W-1:0]  count_q;
	logic                last_q;

	logic                accept;
	req_t                req;
	logic                is_full;
	logic                is_empty;
	logic                mem_we;
	logic                div_start;
	logic [ENTRY_W-1:0]  rd_entry;
	logic [RES_W-1:0]    tquot;
	logic [RES_W-1:0]    hquot;
	logic                tdiv_done;
	logic                hdiv_done;

	assign accept   = start && !busy;
	assign req      = req_t'(req_type);
	assign is_full  = (fill_q == CNT_W'(LOG_DEPTH));
	assign is_empty = (fill_q == '0);

	// A new pair goes into the memory only when logging is on and there is room.
	assign mem_we    = accept && (req == REQ_ADD) && enabled_q && !is_full;
	// Both dividers start together and run the same number of steps.
	assign div_start = accept && (req == REQ_AVG) && enabled_q && !is_empty;

	slstat_store #(
		.DEPTH  (LOG_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata ({humidity, temperature}),
		.re    (state_q == S_DUMP_RD),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_entry)
	);

	slstat_divider #(
		.CNT_W (CNT_W)
	) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({tsum_q, FRAC_W'(0)}),
		.divisor  (fill_q),
		.quotient (tquot),
		.done     (tdiv_done)
	);

	slstat_divider #(
		.CNT_W (CNT_W)
	) u_hdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({hsum_q, FRAC_W'(0)}),
		.divisor  (fill_q),
		.quotient (hquot),
		.done     (hdiv_done)
	);

	// Sequencer: running statistics, request decode and the output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			enabled_q <= 1'b0;
			tsum_q    <= '0;
			hsum_q    <= '0;
			tmin_q    <= '0;
			tmax_q    <= '0;
			hmin_q    <= '0;
			hmax_q    <= '0;
			idx_q     <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			temp_q    <= '0;
			hum_q     <= '0;
			count_q   <= '0;
			last_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// Defaults for a single word with zero values.
						status_q <= ST_OK;
						temp_q   <= '0;
						hum_q    <= '0;
						count_q  <= COUNT_W'(fill_q);
						last_q   <= 1'b1;
						done_q   <= (req != REQ_UNUSED);
						if (!enabled_q && (req == REQ_ADD || req == REQ_AVG ||
								req == REQ_MIN || req == REQ_MAX)) begin
							status_q <= ST_NOINIT;
						end else begin
							unique case (req)
								REQ_ADD: begin
									temp_q <= {temperature, FRAC_W'(0)};
									hum_q  <= {humidity, FRAC_W'(0)};
									if (is_full) begin
										status_q <= ST_FULL;
									end else begin
										if (is_empty || temperature < tmin_q) tmin_q <= temperature;
										if (is_empty || temperature > tmax_q) tmax_q <= temperature;
										if (is_empty || humidity < hmin_q) hmin_q <= humidity;
										if (is_empty || humidity > hmax_q) hmax_q <= humidity;
										tsum_q  <= tsum_q + SUM_W'(temperature);
										hsum_q  <= hsum_q + SUM_W'(humidity);
										fill_q  <= fill_q + 1'b1;
										count_q <= COUNT_W'(fill_q + 1'b1);
									end
								end
								REQ_AVG: begin
									if (is_empty) begin
										status_q <= ST_EMPTY;
									end else begin
										// The word is sent when the dividers finish.
										done_q  <= 1'b0;
										state_q <= S_DIV;
									end
								end
								REQ_MIN: begin
									if (is_empty) begin
										status_q <= ST_EMPTY;
									end else begin
										temp_q <= {tmin_q, FRAC_W'(0)};
										hum_q  <= {hmin_q, FRAC_W'(0)};
									end
								end
								REQ_MAX: begin
									if (is_empty) begin
										status_q <= ST_EMPTY;
									end else begin
										temp_q <= {tmax_q, FRAC_W'(0)};
										hum_q  <= {hmax_q, FRAC_W'(0)};
									end
								end
								REQ_DUMP: begin
									if (is_empty) begin
										status_q <= ST_EMPTY;
									end else begin
										done_q  <= 1'b0;
										idx_q   <= '0;
										state_q <= S_DUMP_RD;
									end
								end
								REQ_CLEAR: begin
									fill_q  <= '0;
									tsum_q  <= '0;
									hsum_q  <= '0;
									tmin_q  <= '0;
									tmax_q  <= '0;
									hmin_q  <= '0;
									hmax_q  <= '0;
									count_q <= '0;
								end
								REQ_INIT: begin
									enabled_q <= (init_size != '0);
								end
								default: begin
									// Code seven is ignored; no word is sent.
								end
							endcase
						end
					end
				end
				S_DIV: begin
					if (tdiv_done && hdiv_done) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						temp_q   <= tquot;
						hum_q    <= hquot;
						count_q  <= COUNT_W'(fill_q);
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_DUMP_RD: begin
					// Read issued this cycle; data arrives next cycle.
					state_q <= S_DUMP_OUT;
				end
				S_DUMP_OUT: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					temp_q   <= {rd_entry[VAL_W-1:0], FRAC_W'(0)};
					hum_q    <= {rd_entry[ENTRY_W-1:VAL_W], FRAC_W'(0)};
					count_q  <= COUNT_W'(fill_q);
					last_q   <= (idx_q + 1'b1 == fill_q);
					idx_q    <= idx_q + 1'b1;
					state_q  <= (idx_q + 1'b1 == fill_q) ? S_IDLE : S_DUMP_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign temp_value  = temp_q;
	assign hum_value   = hum_q;
	assign entry_count = count_q;
	assign last        = last_q;

	// The fill count never passes the depth of the memory.
	`SLS_ASSERT_SAME(a_fill_bounded, clk, arst_n, 1'b1, fill_q <= CNT_W'(LOG_DEPTH))
	// A dropped reading is only reported when the log really is full.
	`SLS_ASSERT_SAME(a_full_only_when_full, clk, arst_n, done && status_q == ST_FULL, is_full)
	// A dump word that is not the last one leaves the sequencer still working.
	`SLS_ASSERT_SAME(a_dump_continues, clk, arst_n, done && !last, busy)
	// The two dividers always finish in the same cycle.
	`SLS_ASSERT_SAME(a_div_lockstep, clk, arst_n, tdiv_done || hdiv_done, tdiv_done && hdiv_done)
	// An accepted add with room grows the log by exactly one entry.
	`SLS_ASSERT_NEXT(a_add_grows, clk, arst_n, mem_we, fill_q == $past(fill_q) + 1'b1)

endmodule

`default_nettype wire

// ----- src/slstat_store.sv -----
// Log memory: one write port and one read port with registered read data.
// Depends on slstat_pkg for the entry width.
`default_nettype none

module slstat_store #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  wire                         clk,
	input  wire                         we,
	input  wire  [ADDR_W-1:0]           waddr,
	input  wire  [slstat_pkg::ENTRY_W-1:0] wdata,
	input  wire                         re,
	input  wire  [ADDR_W-1:0]           raddr,
	output logic [slstat_pkg::ENTRY_W-1:0] rdata
);
	import slstat_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/slstat_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the running average.
// Depends on slstat_pkg for the dividend and result widths.
`default_nettype none

module slstat_divider #(
	parameter int CNT_W = 7
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  [slstat_pkg::DIVIDEND_W-1:0] dividend,
	input  wire  [CNT_W-1:0]                 divisor,
	output logic [slstat_pkg::RES_W-1:0]     quotient,
	output logic                             done
);
	import slstat_pkg::*;

	logic [STEP_W-1:0]     steps_q;
	logic [DIVIDEND_W-1:0] work_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      divisor_q;
	logic                  done_q;
	logic [CNT_W:0]        rem_sh;
	logic                  fits;
	logic [CNT_W:0]        rem_diff;

	// The partial remainder stays below the divisor, so it fits CNT_W bits.
	assign rem_sh   = {rem_q, work_q[DIVIDEND_W-1]};
	assign fits     = rem_sh >= {1'b0, divisor_q};
	assign rem_diff = rem_sh - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				steps_q <= STEP_W'(DIVIDEND_W);
			end else if (steps_q != '0) begin
				steps_q <= steps_q - 1'b1;
				done_q  <= (steps_q == STEP_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (steps_q != '0) begin
			work_q <= {work_q[DIVIDEND_W-2:0], fits};
			rem_q  <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	assign quotient = work_q[RES_W-1:0];
	assign done     = done_q;

endmodule

`default_nettype wire

// ----- sim/sls_reply_check.sv -----
// Reply checker for the sensor log statistics block: tracks accepted request
// words, predicts the reply words of each, and compares every reply word.
// Depends on slstat_pkg for the request and status codes and field widths.
module sls_reply_check #(
	parameter int LOG_DEPTH = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire                              busy,
	input  wire  [slstat_pkg::REQ_W-1:0]     req_type,
	input  wire  [slstat_pkg::VAL_W-1:0]     temperature,
	input  wire  [slstat_pkg::VAL_W-1:0]     humidity,
	input  wire  [25:0]                      init_size,
	input  wire                              done,
	input  wire  [1:0]                       status,
	input  wire  [slstat_pkg::RES_W-1:0]     temp_value,
	input  wire  [slstat_pkg::RES_W-1:0]     hum_value,
	input  wire  [slstat_pkg::COUNT_W-1:0]   entry_count,
	input  wire                              last,
	output int                               errors,
	output int                               pending,
	output int                               words_in,
	output int                               words_out
);
	timeunit 1ns;
	timeprecision 1ps;

	import slstat_pkg::*;

	typedef struct packed {
		status_t              status;
		logic [RES_W-1:0]     temp_value;
		logic [RES_W-1:0]     hum_value;
		logic [COUNT_W-1:0]   entry_count;
		logic                 last;
	} reply_t;

	reply_t reply_q[$];

	// Model of the log and its running statistics.
	logic [VAL_W-1:0]   temp_log [LOG_DEPTH];
	logic [VAL_W-1:0]   hum_log [LOG_DEPTH];
	logic [COUNT_W-1:0] fill = '0;
	logic               logging_on = 1'b0;
	logic [SUM_W-1:0]   temp_sum = '0;
	logic [SUM_W-1:0]   hum_sum = '0;
	logic [VAL_W-1:0]   temp_lo = '0;
	logic [VAL_W-1:0]   temp_hi = '0;
	logic [VAL_W-1:0]   hum_lo = '0;
	logic [VAL_W-1:0]   hum_hi = '0;

	int fail_count = 0;
	int outstanding = 0;
	int accepted = 0;
	int compared = 0;

	assign errors = fail_count;
	assign pending = outstanding;
	assign words_in = accepted;
	assign words_out = compared;

	function automatic void queue_reply(status_t st, logic [RES_W-1:0] tv,
			logic [RES_W-1:0] hv, logic fin);
		reply_t r;
		r.status = st;
		r.temp_value = tv;
		r.hum_value = hv;
		r.entry_count = fill;
		r.last = fin;
		reply_q.push_back(r);
	endfunction

	function automatic void clear_log();
		fill = '0;
		temp_sum = '0;
		hum_sum = '0;
		temp_lo = '0;
		temp_hi = '0;
		hum_lo = '0;
		hum_hi = '0;
	endfunction

	// Updates the model for one request word and queues the replies it causes.
	function automatic void predict_replies(logic [REQ_W-1:0] req, logic [VAL_W-1:0] t,
			logic [VAL_W-1:0] h, logic [25:0] size);
		logic [DIVIDEND_W-1:0] t_quot;
		logic [DIVIDEND_W-1:0] h_quot;
		if (req <= REQ_MAX && !logging_on) begin
			queue_reply(ST_NOINIT, '0, '0, 1'b1);
			return;
		end
		case (req)
			REQ_ADD: begin
				if (fill >= LOG_DEPTH) begin
					queue_reply(ST_FULL, {t, 8'h00}, {h, 8'h00}, 1'b1);
				end else begin
					temp_log[fill] = t;
					hum_log[fill] = h;
					if (fill == 0) begin
						temp_lo = t;
						temp_hi = t;
						hum_lo = h;
						hum_hi = h;
					end else begin
						if (t < temp_lo) temp_lo = t;
						if (t > temp_hi) temp_hi = t;
						if (h < hum_lo) hum_lo = h;
						if (h > hum_hi) hum_hi = h;
					end
					temp_sum = temp_sum + t;
					hum_sum = hum_sum + h;
					fill = fill + 1'b1;
					queue_reply(ST_OK, {t, 8'h00}, {h, 8'h00}, 1'b1);
				end
			end
			REQ_AVG, REQ_MIN, REQ_MAX: begin
				if (fill == 0) begin
					queue_reply(ST_EMPTY, '0, '0, 1'b1);
				end else if (req == REQ_AVG) begin
					t_quot = {temp_sum, 8'h00} / fill;
					h_quot = {hum_sum, 8'h00} / fill;
					queue_reply(ST_OK, t_quot[RES_W-1:0], h_quot[RES_W-1:0], 1'b1);
				end else if (req == REQ_MIN) begin
					queue_reply(ST_OK, {temp_lo, 8'h00}, {hum_lo, 8'h00}, 1'b1);
				end else begin
					queue_reply(ST_OK, {temp_hi, 8'h00}, {hum_hi, 8'h00}, 1'b1);
				end
			end
			REQ_DUMP: begin
				if (fill == 0) begin
					queue_reply(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					for (int k = 0; k < fill; k++)
						queue_reply(ST_OK, {temp_log[k], 8'h00}, {hum_log[k], 8'h00},
							k == fill - 1);
				end
			end
			REQ_CLEAR: begin
				clear_log();
				queue_reply(ST_OK, '0, '0, 1'b1);
			end
			REQ_INIT: begin
				logging_on = (size != 0);
				queue_reply(ST_OK, '0, '0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			clear_log();
			logging_on = 1'b0;
			reply_q.delete();
			outstanding = 0;
		end else begin
			// Replies are compared before the new request is predicted, so a
			// reply can never be matched against an expectation of its own cycle.
			if (done === 1'b1) begin
				compared++;
				if (reply_q.size() == 0) begin
					$error("reply word with no request waiting for it");
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (temp_value !== want.temp_value) begin
						$error("temp_value: expected %0h, got %0h", want.temp_value,
							temp_value);
						fail_count++;
					end
					if (hum_value !== want.hum_value) begin
						$error("hum_value: expected %0h, got %0h", want.hum_value,
							hum_value);
						fail_count++;
					end
					if (entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count,
							entry_count);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						fail_count++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				accepted++;
				predict_replies(req_type, temperature, humidity, init_size);
			end
			outstanding = reply_q.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
// Top of the sensor log statistics testbench: clock, reset, request stimulus
// and the verdict. Depends on slstat_pkg, the block and sls_reply_check.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import slstat_pkg::*;

	localparam int               LOG_DEPTH = 64;
	localparam int               SIZE_W = 26;
	localparam logic [SIZE_W-1:0] SIZE_MAX = 26'h3FFFFFF;
	localparam logic [VAL_W-1:0] VAL_MAX = 13'h1FFF;
	// Longest quiet stretch the block may need after its last reply word.
	localparam int               DRAIN_CYCLES = 64;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [REQ_W-1:0]     req_type;
	logic [VAL_W-1:0]     temperature;
	logic [VAL_W-1:0]     humidity;
	logic [SIZE_W-1:0]    init_size;
	logic                 done;
	logic [1:0]           status;
	logic [RES_W-1:0]     temp_value;
	logic [RES_W-1:0]     hum_value;
	logic [COUNT_W-1:0]   entry_count;
	logic                 last;

	int errors;
	int pending;
	int words_in;
	int words_out;

	// When set, the sender keeps start high back to back with no idle cycles.
	bit steady = 1'b0;

	sensor_log_statistics #(.LOG_DEPTH(LOG_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.temperature(temperature),
		.humidity(humidity),
		.init_size(init_size),
		.done(done),
		.status(status),
		.temp_value(temp_value),
		.hum_value(hum_value),
		.entry_count(entry_count),
		.last(last)
	);

	// The checker watches both channels and owns all prediction; this module
	// only makes requests and reads back the counts it reports.
	sls_reply_check #(.LOG_DEPTH(LOG_DEPTH)) reply_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.temperature(temperature),
		.humidity(humidity),
		.init_size(init_size),
		.done(done),
		.status(status),
		.temp_value(temp_value),
		.hum_value(hum_value),
		.entry_count(entry_count),
		.last(last),
		.errors(errors),
		.pending(pending),
		.words_in(words_in),
		.words_out(words_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog. A correct run takes well under a tenth of this time, even with
	// every dump walking a full log and every gap at its longest.
	initial begin
		#2000000;
		$display("testbench: done, errors");
		$finish;
	end

	// Readings lean toward the ends of the range so that the minimum, maximum
	// and the widest sums are hit often, with uniform values in between.
	function automatic logic [VAL_W-1:0] random_reading();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return VAL_MAX;
			default: return $urandom_range(0, VAL_MAX);
		endcase
	endfunction

	// Init payload: a quarter zero (disables logging), a quarter all ones, the
	// rest random nonzero so that every bit takes both values.
	function automatic logic [SIZE_W-1:0] random_size();
		logic [SIZE_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = '0;
			1: v = SIZE_MAX;
			default: begin
				v = SIZE_W'($urandom);
				if (v == 0)
					v = 1;
			end
		endcase
		return v;
	endfunction

	// Presents one request word from a falling edge and holds it until a rising
	// edge sees busy low. Start is left high; the caller lowers it in a gap, so
	// back-to-back words never lower and raise start in the same time step.
	task automatic send_word(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] t,
			input logic [VAL_W-1:0] h, input logic [SIZE_W-1:0] size);
		start <= 1'b1;
		req_type <= req;
		temperature <= t;
		humidity <= h;
		init_size <= size;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		@(negedge clk);
	endtask

	// Sender idle time: mostly none or short, now and then a long one.
	// Field values wander while start is low, since the block must ignore them.
	task automatic idle_gap();
		int pick;
		int gap;
		pick = $urandom_range(0, 99);
		if (steady || pick < 55)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			start <= 1'b0;
			req_type <= REQ_W'($urandom);
			temperature <= random_reading();
			humidity <= random_reading();
			init_size <= random_size();
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic request(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] t,
			input logic [VAL_W-1:0] h, input logic [SIZE_W-1:0] size);
		send_word(req, t, h, size);
		idle_gap();
	endtask

	// Random mix weighted toward adds so the log grows between clears. The
	// unused code and disabling inits appear often enough to matter.
	task automatic random_request();
		int pick;
		logic [REQ_W-1:0] req;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			req = REQ_ADD;
		else if (pick < 58)
			req = REQ_AVG;
		else if (pick < 65)
			req = REQ_MIN;
		else if (pick < 72)
			req = REQ_MAX;
		else if (pick < 79)
			req = REQ_DUMP;
		else if (pick < 83)
			req = REQ_CLEAR;
		else if (pick < 93)
			req = REQ_INIT;
		else
			req = REQ_UNUSED;
		request(req, random_reading(), random_reading(), random_size());
	endtask

	// Drops start and waits until every reply has arrived.
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_ADD;
		temperature = '0;
		humidity = '0;
		init_size = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Out of reset logging is off, so the statistics and
		// add must all answer not-initialized, while dump and clear still work.
		request(REQ_ADD, VAL_MAX, '0, '0);
		request(REQ_AVG, '0, '0, '0);
		request(REQ_MIN, '0, '0, '0);
		request(REQ_MAX, '0, '0, '0);
		request(REQ_DUMP, '0, '0, '0);
		request(REQ_CLEAR, '0, '0, '0);
		request(REQ_INIT, '0, '0, '0);
		// Enable with the largest size; statistics on the empty log say empty.
		request(REQ_INIT, '0, '0, SIZE_MAX);
		request(REQ_AVG, '0, '0, '0);
		request(REQ_MIN, '0, '0, '0);
		request(REQ_MAX, '0, '0, '0);
		// Both ends of the reading range and alternating bit patterns.
		request(REQ_ADD, '0, '0, '0);
		request(REQ_ADD, VAL_MAX, VAL_MAX, '0);
		request(REQ_ADD, 13'h1555, 13'h0AAA, '0);
		request(REQ_AVG, '0, '0, '0);
		request(REQ_MIN, '0, '0, '0);
		request(REQ_MAX, '0, '0, '0);
		request(REQ_DUMP, '0, '0, '0);
		request(REQ_UNUSED, VAL_MAX, VAL_MAX, SIZE_MAX);
		// Disabling keeps the entries: add is refused but dump still replays.
		request(REQ_INIT, '0, '0, '0);
		request(REQ_ADD, 13'h0AAA, 13'h1555, '0);
		request(REQ_DUMP, '0, '0, '0);
		request(REQ_CLEAR, '0, '0, '0);
		request(REQ_DUMP, '0, '0, '0);
		request(REQ_INIT, '0, '0, 26'd1);

		repeat (90) random_request();

		// Let the block run completely dry once before the next phase.
		wait_drained();

		// Fill the log to capacity with no idle cycles between adds, push past
		// the end so that full is reported, then query and replay the full log.
		request(REQ_INIT, '0, '0, SIZE_MAX);
		request(REQ_CLEAR, '0, '0, '0);
		steady = 1'b1;
		repeat (LOG_DEPTH + 4) request(REQ_ADD, random_reading(), random_reading(),
			random_size());
		steady = 1'b0;
		request(REQ_AVG, '0, '0, '0);
		request(REQ_MIN, '0, '0, '0);
		request(REQ_MAX, '0, '0, '0);
		request(REQ_DUMP, '0, '0, '0);
		request(REQ_ADD, VAL_MAX, '0, '0);
		request(REQ_CLEAR, '0, '0, '0);

		repeat (90) random_request();

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("testbench: %0d request words accepted, %0d reply words checked",
			words_in, words_out);
		$display("testbench: all request codes, logging off, empty and full log seen");
		if (errors == 0 && pending == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
